### rtl/plss_pkg.sv
// plss_pkg: widths, state codes and helpers for the level-set splat block
// no dependencies; used by plss_div, plss_sqrt and particle_level_set_splat
package plss_pkg;

	localparam int GRID_DIM = 32;
	localparam int IDX_W    = $clog2(GRID_DIM);
	localparam int ADDR_W   = 3 * IDX_W;
	localparam int SIZE_W   = 6;
	localparam int POS_W    = 32;
	localparam int DX_W     = 24;
	localparam int DIST_W   = 32;
	localparam int ABSD_W   = DX_W + 2;
	localparam int SQ_W     = 2 * ABSD_W;
	localparam int ACC_W    = SQ_W + 2;
	localparam int RAD_W    = ACC_W - 2;
	localparam int ROOT_W   = RAD_W / 2;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_SPLAT  = 2'd1;
	localparam logic [1:0] OP_FINAL  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] REG_SIZE_X = 3'd0;
	localparam logic [2:0] REG_SIZE_Y = 3'd1;
	localparam logic [2:0] REG_SIZE_Z = 3'd2;
	localparam logic [2:0] REG_CELL   = 3'd3;
	localparam logic [2:0] REG_RADIUS = 3'd4;

	// size in use: 0 acts as 1, above the grid acts as the grid
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		if (s == '0) r = SIZE_W'(1);
		else if (s > SIZE_W'(GRID_DIM)) r = SIZE_W'(GRID_DIM);
		else r = s;
		return r;
	endfunction

endpackage

### rtl/plss_div.sv
// plss_div: restoring divider, one quotient bit per cycle
// depends on plss_pkg
module plss_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [plss_pkg::POS_W-1:0]    dividend,
	input  logic [plss_pkg::DX_W-1:0]     divisor,
	output logic                          done,
	output logic [plss_pkg::POS_W-1:0]    quotient
);
	logic                               busy_q;
	logic [$clog2(plss_pkg::POS_W)-1:0] cnt_q;
	logic [plss_pkg::POS_W-1:0]         num_q;
	logic [plss_pkg::POS_W-1:0]         quo_q;
	logic [plss_pkg::DX_W-1:0]          rem_q;
	logic [plss_pkg::DX_W-1:0]          dvs_q;
	logic                               done_q;
	logic [plss_pkg::DX_W:0]            trial;
	logic                               ge;

	assign trial = {rem_q, num_q[plss_pkg::POS_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[plss_pkg::POS_W-2:0], 1'b0};
			rem_q <= ge ? plss_pkg::DX_W'(trial - {1'b0, dvs_q}) : trial[plss_pkg::DX_W-1:0];
			quo_q <= {quo_q[plss_pkg::POS_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

### rtl/plss_sqrt.sv
// plss_sqrt: digit-by-digit integer square root, one result bit per cycle
// depends on plss_pkg
module plss_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [plss_pkg::RAD_W-1:0]    radicand,
	output logic                          done,
	output logic [plss_pkg::ROOT_W-1:0]   root
);
	logic                                busy_q;
	logic [$clog2(plss_pkg::ROOT_W)-1:0] cnt_q;
	logic                                done_q;
	logic [plss_pkg::RAD_W-1:0]          v_q;
	logic [plss_pkg::RAD_W-1:0]          res_q;
	logic [plss_pkg::RAD_W-1:0]          bit_q;
	logic [plss_pkg::RAD_W-1:0]          t;

	assign t = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(plss_pkg::ROOT_W))'(plss_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= plss_pkg::RAD_W'(1) << (plss_pkg::RAD_W - 2);
		end else if (busy_q) begin
			if (v_q >= t) begin
				v_q   <= v_q - t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[plss_pkg::ROOT_W-1:0];
endmodule

### rtl/particle_level_set_splat.sv
// particle_level_set_splat: top level, sequencer, grid memory and config registers
// depends on plss_pkg, plss_div and plss_sqrt
//
// one item at a time: s_axis_tready is high only while the sequencer is idle. a clear
// writes all 32768 cells, one a cycle. a splat runs the shared divider three times, once
// per axis, then for each cell of the clamped 3x3x3 neighborhood forms three axis
// differences through one multiplier and a 26-step square root. a finalize reads and
// possibly rewrites one cell. the result word waits in an output register; a new item
// is taken once the sequencer is idle again.
module particle_level_set_splat (
	input  logic         clk,
	input  logic         arst_n,
	// apb configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input words
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,  // pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, solid_inside
	input  logic [1:0]   s_axis_tuser,  // op
	// result words
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [31:0]  m_axis_tdata,  // distance
	output logic [1:0]   m_axis_tuser   // done_op
);
	localparam int IW = plss_pkg::IDX_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLR  = 4'd1;
	localparam logic [3:0] ST_DIVS = 4'd2;
	localparam logic [3:0] ST_DIVW = 4'd3;
	localparam logic [3:0] ST_DIFF = 4'd4;
	localparam logic [3:0] ST_SQR  = 4'd5;
	localparam logic [3:0] ST_ACC  = 4'd6;
	localparam logic [3:0] ST_SQW  = 4'd7;
	localparam logic [3:0] ST_UPD  = 4'd8;
	localparam logic [3:0] ST_FRD  = 4'd9;
	localparam logic [3:0] ST_FCHK = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	// configuration registers
	logic [plss_pkg::SIZE_W-1:0] size_q [3];
	logic [plss_pkg::DX_W-1:0]   cell_size_q;
	logic [plss_pkg::DX_W-1:0]   radius_q;
	logic                        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q[0]   <= plss_pkg::SIZE_W'(plss_pkg::GRID_DIM);
			size_q[1]   <= plss_pkg::SIZE_W'(plss_pkg::GRID_DIM);
			size_q[2]   <= plss_pkg::SIZE_W'(plss_pkg::GRID_DIM);
			cell_size_q <= plss_pkg::DX_W'(65536);
			radius_q    <= plss_pkg::DX_W'(32768);
		end else if (cfg_we) begin
			case (paddr[4:2])
				plss_pkg::REG_SIZE_X: size_q[0]   <= pwdata[plss_pkg::SIZE_W-1:0];
				plss_pkg::REG_SIZE_Y: size_q[1]   <= pwdata[plss_pkg::SIZE_W-1:0];
				plss_pkg::REG_SIZE_Z: size_q[2]   <= pwdata[plss_pkg::SIZE_W-1:0];
				plss_pkg::REG_CELL:   cell_size_q <= pwdata[plss_pkg::DX_W-1:0];
				plss_pkg::REG_RADIUS: radius_q    <= pwdata[plss_pkg::DX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			plss_pkg::REG_SIZE_X: prdata = 32'(size_q[0]);
			plss_pkg::REG_SIZE_Y: prdata = 32'(size_q[1]);
			plss_pkg::REG_SIZE_Z: prdata = 32'(size_q[2]);
			plss_pkg::REG_CELL:   prdata = 32'(cell_size_q);
			plss_pkg::REG_RADIUS: prdata = 32'(radius_q);
			default:              prdata = '0;
		endcase
	end

	// zero cell size acts as one
	logic [plss_pkg::DX_W-1:0] dx;
	assign dx = (cell_size_q == '0) ? plss_pkg::DX_W'(1) : cell_size_q;

	// item registers
	logic [3:0]                 state_q;
	logic [1:0]                 op_q;
	logic [plss_pkg::POS_W-1:0] pos_q [3];
	logic                       solid_q;
	logic [IW-1:0]              idx_q [3];
	logic [IW-1:0]              lo_q  [3];
	logic [IW-1:0]              hi_q  [3];
	logic [1:0]                 ax_q;
	logic                       empty_q;
	logic [plss_pkg::ADDR_W-1:0] clr_q;
	logic [plss_pkg::ABSD_W-1:0] absd_q;
	logic [plss_pkg::SQ_W-1:0]   sq_q;
	logic [plss_pkg::ACC_W-1:0]  acc_q;
	logic [plss_pkg::ACC_W-1:0]  acc_next;
	logic [plss_pkg::DIST_W-1:0] res_q;

	logic s_acc;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// result word moves into the output register
	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

	// running sum of squared axis differences
	assign acc_next = ((ax_q == 2'd0) ? '0 : acc_q) + plss_pkg::ACC_W'(sq_q);

	// shared divider and square root units
	logic                       div_start, div_done;
	logic [plss_pkg::POS_W-1:0] div_q;
	logic                       sq_start, sq_done;
	logic [plss_pkg::ROOT_W-1:0] root;

	assign div_start = (state_q == ST_DIVS);
	assign sq_start  = (state_q == ST_ACC) && (ax_q == 2'd2);

	plss_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(pos_q[ax_q]), .divisor(dx), .done(div_done), .quotient(div_q)
	);

	// the root starts on the complete sum of all three axes
	plss_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.radicand(acc_next[plss_pkg::ACC_W-1:2]), .done(sq_done), .root(root)
	);

	// neighborhood clamp for the axis just divided
	logic [plss_pkg::SIZE_W-1:0] sz_eff;
	logic [IW-1:0]               sz_m1;
	logic [plss_pkg::POS_W:0]    g_p1;
	logic [plss_pkg::POS_W-1:0]  g_lo;
	logic [IW-1:0]               g_hi;
	logic                        g_empty;

	assign sz_eff  = plss_pkg::eff_size(size_q[ax_q]);
	assign sz_m1   = IW'(sz_eff - 1'b1);
	assign g_p1    = {1'b0, div_q} + 1'b1;
	assign g_lo    = (div_q == '0) ? '0 : div_q - 1'b1;
	assign g_hi    = (g_p1 > (plss_pkg::POS_W+1)'(sz_m1)) ? sz_m1 : g_p1[IW-1:0];
	assign g_empty = g_lo > plss_pkg::POS_W'(g_hi);

	// axis difference in half units: (2i+1)*dx - 2*pos
	logic [IW+plss_pkg::DX_W:0]  ctr;
	logic signed [plss_pkg::POS_W+2:0] dsig;
	logic [plss_pkg::POS_W+2:0]  dabs;

	assign ctr  = {idx_q[ax_q], 1'b1} * dx;
	assign dsig = $signed((plss_pkg::POS_W+3)'(ctr))
	            - $signed({2'b00, pos_q[ax_q], 1'b0});
	assign dabs = dsig[plss_pkg::POS_W+2] ? (plss_pkg::POS_W+3)'(-dsig)
	                                      : (plss_pkg::POS_W+3)'(dsig);

	// grid memory
	logic [plss_pkg::DIST_W-1:0] grid_mem [2**plss_pkg::ADDR_W];
	logic [plss_pkg::DIST_W-1:0] rdata_q;
	logic [plss_pkg::ADDR_W-1:0] cell_addr;
	logic                        mem_we;
	logic [plss_pkg::ADDR_W-1:0] mem_wa;
	logic [plss_pkg::DIST_W-1:0] mem_wd;

	assign cell_addr = {idx_q[2], idx_q[1], idx_q[0]};

	logic signed [plss_pkg::DIST_W-1:0] splat_dist;
	logic                               fin_low;
	logic [plss_pkg::DIST_W-1:0]        fin_val;

	assign splat_dist = $signed(plss_pkg::DIST_W'(root)) - $signed(plss_pkg::DIST_W'(radius_q));
	assign fin_low = $signed({rdata_q[plss_pkg::DIST_W-1], rdata_q, 1'b0})
	               < $signed((plss_pkg::DIST_W+2)'(dx));
	assign fin_val = plss_pkg::DIST_W'(-$signed(plss_pkg::DIST_W'(dx >> 1)));

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cell_addr;
		mem_wd = plss_pkg::DIST_W'(splat_dist);
		case (state_q)
			ST_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = plss_pkg::DIST_W'(3 * dx);
			end
			ST_UPD: mem_we = splat_dist < $signed(rdata_q);
			ST_FCHK: begin
				mem_we = fin_low && solid_q;
				mem_wd = fin_val;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) grid_mem[mem_wa] <= mem_wd;
		rdata_q <= grid_mem[cell_addr];
	end

	// finalize cell in range
	logic fin_in;
	assign fin_in = (plss_pkg::SIZE_W'(idx_q[0]) < plss_pkg::eff_size(size_q[0]))
	             && (plss_pkg::SIZE_W'(idx_q[1]) < plss_pkg::eff_size(size_q[1]))
	             && (plss_pkg::SIZE_W'(idx_q[2]) < plss_pkg::eff_size(size_q[2]));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ax_q          <= '0;
			empty_q       <= 1'b0;
			clr_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (out_load) m_axis_tvalid <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_acc) begin
					res_q   <= '0;
					ax_q    <= '0;
					empty_q <= 1'b0;
					clr_q   <= '0;
					// finalize names its cell directly
					if (s_axis_tuser == plss_pkg::OP_FINAL) begin
						idx_q[0] <= s_axis_tdata[100:96];
						idx_q[1] <= s_axis_tdata[105:101];
						idx_q[2] <= s_axis_tdata[110:106];
					end
					case (s_axis_tuser)
						plss_pkg::OP_CLEAR: state_q <= ST_CLR;
						plss_pkg::OP_SPLAT: state_q <= ST_DIVS;
						plss_pkg::OP_FINAL: state_q <= ST_FRD;
						default:            state_q <= ST_DONE;
					endcase
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= ST_DONE;
				end
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: if (div_done) begin
					lo_q[ax_q]  <= g_lo[IW-1:0];
					idx_q[ax_q] <= g_lo[IW-1:0];
					hi_q[ax_q]  <= g_hi;
					if (g_empty || empty_q) empty_q <= 1'b1;
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= (g_empty || empty_q) ? ST_DONE : ST_DIFF;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_DIVS;
					end
				end
				ST_DIFF: begin
					absd_q  <= dabs[plss_pkg::ABSD_W-1:0];
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					sq_q    <= absd_q * absd_q;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q <= acc_next;
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= ST_SQW;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_DIFF;
					end
				end
				ST_SQW: if (sq_done) state_q <= ST_UPD;
				ST_UPD: begin
					// step x fastest, then y, then z
					state_q <= ST_DIFF;
					if (idx_q[0] != hi_q[0]) begin
						idx_q[0] <= idx_q[0] + 1'b1;
					end else begin
						idx_q[0] <= lo_q[0];
						if (idx_q[1] != hi_q[1]) begin
							idx_q[1] <= idx_q[1] + 1'b1;
						end else begin
							idx_q[1] <= lo_q[1];
							if (idx_q[2] != hi_q[2]) idx_q[2] <= idx_q[2] + 1'b1;
							else state_q <= ST_DONE;
						end
					end
				end
				ST_FRD: state_q <= fin_in ? ST_FCHK : ST_DONE;
				ST_FCHK: begin
					res_q   <= (fin_low && solid_q) ? fin_val : rdata_q;
					state_q <= ST_DONE;
				end
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload capture
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q     <= s_axis_tuser;
			pos_q[0] <= s_axis_tdata[31:0];
			pos_q[1] <= s_axis_tdata[63:32];
			pos_q[2] <= s_axis_tdata[95:64];
			solid_q  <= s_axis_tdata[111];
		end
		if (out_load) begin
			m_axis_tdata <= res_q;
			m_axis_tuser <= op_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after accepting a word");
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLR || state_q == ST_UPD || state_q == ST_FCHK))
		else $error("grid written outside clear, update or finalize");
	a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ST_SQW)
		else $error("square root finished while not awaited");
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> (idx_q[0] >= lo_q[0] && idx_q[0] <= hi_q[0]
			&& idx_q[2] <= hi_q[2]))
		else $error("walk index outside neighborhood");
`endif
endmodule

### dv/testbench.sv
// testbench for particle_level_set_splat: drives clear, splat, finalize and unused-op words over the
// input stream and checks every result word against a predictor with its own grid copy
// depends on plss_pkg and the particle_level_set_splat rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS = 32 * 32 * 32;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] px, py, pz;
		logic [4:0]  cx, cy, cz;
		logic        solid;
	} particle_word_t;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] distance;
	} grid_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata = '0;  // pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, solid_inside
	logic [1:0]   s_axis_tuser = '0;  // op
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [31:0]  m_axis_tdata;       // distance
	logic [1:0]   m_axis_tuser;       // done_op

	// predictor state: grid copy and register shadows
	int           level_grid [CELLS];
	logic [5:0]   span_x = 6'd32, span_y = 6'd32, span_z = 6'd32;
	logic [23:0]  cell_edge = 24'd65536, splat_radius = 24'd32768;
	grid_result_t pending_results [$];
	int           mismatches = 0;
	int           hold_off = 0;   // receiver stall length requested by a test
	bit           quiet_out = 0;  // no random receiver stalls

	always #4 clk = ~clk;

	particle_level_set_splat dut (.*);

	function automatic int unsigned span_in_use(logic [5:0] s);
		if (s == 0) return 1;
		if (s > 32) return 32;
		return s;
	endfunction

	function automatic longint unsigned edge_in_use();
		return (cell_edge == 0) ? 1 : cell_edge;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// neighborhood [g-1, g+1] clipped to the span; empty when it lies past the edge
	function automatic bit clip_axis(longint unsigned g, int unsigned span,
			output int unsigned lo, output int unsigned hi);
		longint unsigned l, h;
		l = (g == 0) ? 0 : g - 1;
		h = g + 1;
		if (h > span - 1) h = span - 1;
		lo = 32'(l);
		hi = 32'(h);
		return l <= h;
	endfunction

	function automatic longint unsigned axis_sq(int unsigned idx, longint unsigned e,
			logic [31:0] p);
		longint d;
		d = longint'((2 * idx + 1) * e) - 2 * longint'({32'd0, p});
		if (d < 0) d = -d;
		return d * d;
	endfunction

	function automatic void splat_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		int unsigned lx, hx, ly, hy, lz, hz, a;
		longint unsigned e, s;
		int d;
		e = edge_in_use();
		if (!clip_axis(px / e, span_in_use(span_x), lx, hx)) return;
		if (!clip_axis(py / e, span_in_use(span_y), ly, hy)) return;
		if (!clip_axis(pz / e, span_in_use(span_z), lz, hz)) return;
		for (int k = lz; k <= hz; k++)
			for (int j = ly; j <= hy; j++)
				for (int i = lx; i <= hx; i++) begin
					s = axis_sq(i, e, px) + axis_sq(j, e, py) + axis_sq(k, e, pz);
					d = int'(longint'(int_sqrt(s >> 2)) - longint'({40'd0, splat_radius}));
					a = i + j * 32 + k * 1024;
					if (d < level_grid[a]) level_grid[a] = d;
				end
	endfunction

	function automatic grid_result_t predict_word(particle_word_t w);
		grid_result_t r;
		int unsigned a;
		longint unsigned e;
		r.op = w.op;
		r.distance = '0;
		e = edge_in_use();
		case (w.op)
			plss_pkg::OP_CLEAR: foreach (level_grid[n]) level_grid[n] = int'(3 * e);
			plss_pkg::OP_SPLAT: splat_particle(w.px, w.py, w.pz);
			plss_pkg::OP_FINAL: begin
				if (w.cx < span_in_use(span_x) && w.cy < span_in_use(span_y)
						&& w.cz < span_in_use(span_z)) begin
					a = w.cx + w.cy * 32 + w.cz * 1024;
					// solid cells near the surface snap to minus half a cell
					if (2 * longint'(level_grid[a]) < longint'(e) && w.solid)
						level_grid[a] = -int'(e >> 1);
					r.distance = level_grid[a];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// result check first, then prediction of a newly accepted word
	always @(posedge clk) begin
		grid_result_t exp_r;
		particle_word_t w;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word op %0d distance %h",
						m_axis_tuser, m_axis_tdata);
			end else begin
				exp_r = pending_results.pop_front();
				if (exp_r.op !== m_axis_tuser || exp_r.distance !== m_axis_tdata) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected op %0d distance %h, got op %0d distance %h",
							exp_r.op, exp_r.distance, m_axis_tuser, m_axis_tdata);
				end
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			w.op = s_axis_tuser;
			{w.solid, w.cz, w.cy, w.cx, w.pz, w.py, w.px} = s_axis_tdata[111:0];
			pending_results.push_back(predict_word(w));
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// receiver: random stalls, or a long hold-off when a test asks for one
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_axis_tready <= 1'b0;
				hold_off--;
			end else if (quiet_out) begin
				m_axis_tready <= 1'b1;
			end else begin
				stall = pick_gap();
				m_axis_tready <= (stall == 0);
				if (stall > 1) repeat (stall - 1) @(negedge clk);
			end
		end
	end

	initial begin
		#100ms;
		$display("particle_level_set_splat regression: fail");
		$finish;
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			plss_pkg::REG_SIZE_X: span_x = value[5:0];
			plss_pkg::REG_SIZE_Y: span_y = value[5:0];
			plss_pkg::REG_SIZE_Z: span_z = value[5:0];
			plss_pkg::REG_CELL:   cell_edge = value[23:0];
			plss_pkg::REG_RADIUS: splat_radius = value[23:0];
			default: ;
		endcase
	endtask

	task automatic send_word(particle_word_t w, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= w.op;
		s_axis_tdata <= {w.solid, w.cz, w.cy, w.cx, w.pz, w.py, w.px};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic configure(logic [5:0] x, logic [5:0] y, logic [5:0] z,
			logic [23:0] e, logic [23:0] rad);
		drain();
		write_reg(plss_pkg::REG_SIZE_X, 32'(x));
		write_reg(plss_pkg::REG_SIZE_Y, 32'(y));
		write_reg(plss_pkg::REG_SIZE_Z, 32'(z));
		write_reg(plss_pkg::REG_CELL, 32'(e));
		write_reg(plss_pkg::REG_RADIUS, 32'(rad));
	endtask

	function automatic particle_word_t make_word(logic [1:0] op, logic [31:0] px = 0,
			logic [31:0] py = 0, logic [31:0] pz = 0, logic [4:0] cx = 0,
			logic [4:0] cy = 0, logic [4:0] cz = 0, logic solid = 0);
		particle_word_t w;
		w = '{op, px, py, pz, cx, cy, cz, solid};
		return w;
	endfunction

	// position mostly inside or just around the grid in use, sometimes anywhere
	function automatic logic [31:0] rand_pos(int unsigned span);
		longint unsigned lim;
		if ($urandom_range(0, 9) == 0) return $urandom;
		lim = (span + 1) * edge_in_use();
		if (lim > 32'hFFFF_FFFF) lim = 32'hFFFF_FFFF;
		return $urandom_range(0, 32'(lim));
	endfunction

	function automatic logic [4:0] rand_cell(int unsigned span);
		if ($urandom_range(0, 7) == 0) return 5'($urandom_range(0, 31));
		return 5'($urandom_range(0, span - 1));
	endfunction

	function automatic particle_word_t rand_word(bit allow_clear);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (allow_clear && pick == 0) return make_word(plss_pkg::OP_CLEAR);
		if (pick < 3) return make_word(plss_pkg::OP_UNUSED, $urandom, $urandom, $urandom,
			5'($urandom), 5'($urandom), 5'($urandom), 1'($urandom));
		if (pick < 45)
			return make_word(plss_pkg::OP_SPLAT, rand_pos(span_in_use(span_x)),
				rand_pos(span_in_use(span_y)), rand_pos(span_in_use(span_z)),
				5'($urandom), 5'($urandom), 5'($urandom), 1'($urandom));
		return make_word(plss_pkg::OP_FINAL, $urandom, $urandom, $urandom,
			rand_cell(span_in_use(span_x)), rand_cell(span_in_use(span_y)),
			rand_cell(span_in_use(span_z)), 1'($urandom_range(0, 1)));
	endfunction

	task automatic run_random(int count);
		repeat (count) send_word(rand_word(1));
	endtask

	// reset values, every op, corners and the finalize threshold
	task automatic test_directed();
		send_word(make_word(plss_pkg::OP_CLEAR));
		send_word(make_word(plss_pkg::OP_FINAL, 0, 0, 0, 0, 0, 0, 1));
		send_word(make_word(plss_pkg::OP_SPLAT, 0, 0, 0));
		send_word(make_word(plss_pkg::OP_FINAL, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(plss_pkg::OP_FINAL, 0, 0, 0, 1, 1, 1, 1));
		send_word(make_word(plss_pkg::OP_SPLAT, 32'h001F_8000, 32'h001F_8000,
			32'h001F_8000));
		send_word(make_word(plss_pkg::OP_FINAL, 0, 0, 0, 31, 31, 31, 1));
		send_word(make_word(plss_pkg::OP_FINAL, 0, 0, 0, 30, 31, 31, 1));
		// particle far past the grid leaves it alone
		send_word(make_word(plss_pkg::OP_SPLAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_word(make_word(plss_pkg::OP_SPLAT, 32'h0020_0000, 0, 0));
		send_word(make_word(plss_pkg::OP_SPLAT, 32'h0012_3456, 32'h0004_0000,
			32'h000A_C000));
		send_word(make_word(plss_pkg::OP_FINAL, 0, 0, 0, 18, 4, 10, 1));
		send_word(make_word(plss_pkg::OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 31, 31, 31, 1));
		send_word(make_word(plss_pkg::OP_FINAL, 0, 0, 0, 31, 0, 0, 0));
	endtask

	// single-cell grid with the widest cell and no radius
	task automatic test_tiny_grid();
		configure(6'd1, 6'd1, 6'd1, 24'hFF_FFFF, 24'd0);
		send_word(make_word(plss_pkg::OP_CLEAR));
		send_word(make_word(plss_pkg::OP_FINAL, 0, 0, 0, 1, 0, 0, 1));
		send_word(make_word(plss_pkg::OP_SPLAT, 32'h00FF_FFFF, 32'h007F_FFFF, 32'h0));
		send_word(make_word(plss_pkg::OP_SPLAT, 32'h01FF_FFFE, 0, 0));
		send_word(make_word(plss_pkg::OP_FINAL, 0, 0, 0, 0, 0, 0, 1));
		run_random(100);
	endtask

	// out-of-range sizes and a zero cell edge, big radius
	task automatic test_odd_settings();
		configure(6'd0, 6'd63, 6'd33, 24'd0, 24'hFF_FFFF);
		send_word(make_word(plss_pkg::OP_CLEAR));
		send_word(make_word(plss_pkg::OP_SPLAT, 32'd31, 32'd5, 32'd0));
		send_word(make_word(plss_pkg::OP_FINAL, 0, 0, 0, 0, 5, 0, 1));
		send_word(make_word(plss_pkg::OP_FINAL, 0, 0, 0, 1, 31, 31, 0));
		run_random(100);
	endtask

	// receiver holds off while words keep coming, so the input stalls
	task automatic test_backpressure();
		configure(6'd8, 6'd5, 6'd12, 24'h00_4000, 24'h00_2000);
		send_word(make_word(plss_pkg::OP_CLEAR));
		drain();
		hold_off = 4000;
		repeat (8) send_word(rand_word(0), 1);
		drain();
		quiet_out = 1;
		repeat (40) send_word(rand_word(0), 1);
		quiet_out = 0;
		run_random(100);
	endtask

	task automatic test_random_settings();
		repeat (4) begin
			configure(6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)),
				6'($urandom_range(1, 32)),
				24'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 16)),
				24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 20)));
			send_word(make_word(plss_pkg::OP_CLEAR));
			run_random(150);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		run_random(60);
		test_tiny_grid();
		test_odd_settings();
		test_backpressure();
		test_random_settings();
		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("particle_level_set_splat regression: pass");
		else
			$display("particle_level_set_splat regression: fail");
		$finish;
	end

endmodule
